// ===== design/bffra_pkg.sv =====
package bffra_pkg;

	localparam int BYTES_W    = 21;
	localparam int SIZE_W     = 14;
	localparam int COUNT_W    = 8;
	localparam int START_W    = 7;
	localparam int STAT_W     = 2;
	localparam int USED_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	// dividend is bytes + size - 1
	localparam int DIV_W = 22;

	// occupancy map word
	localparam int WORD_W  = 8;
	localparam int WORD_SH = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SIZE  = 1'b1;

	localparam logic [COUNT_W-1:0] RST_ENTRY_COUNT = 8'd128;
	localparam logic [SIZE_W-1:0]  RST_ENTRY_SIZE  = 14'd64;

	localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_SPACE     = 2'd1;
	localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 2'd2;

	localparam logic [USED_W-1:0] USED_MAX = 8'd128;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_res_t;

endpackage

// ===== design/bffra_div.sv =====
module bffra_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [bffra_pkg::BYTES_W-1:0]  bytes,
	input  logic [bffra_pkg::SIZE_W-1:0]   size,
	output bffra_pkg::div_res_t            res
);
	import bffra_pkg::*;

	// restoring divide, two quotient bits per cycle
	localparam int STEPS  = DIV_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SIZE_W-1:0] dv_q;
	logic [SIZE_W-1:0] rem_q;
	logic [DIV_W-1:0]  num_q;

	logic [SIZE_W-1:0] dv_c;
	logic [DIV_W-1:0]  num_c;
	logic [SIZE_W-1:0] rem_c;
	logic [DIV_W-1:0]  numsh_c;
	logic [SIZE_W:0]   trial_c;

	always_comb begin
		dv_c    = (size == '0) ? SIZE_W'(1) : size;
		num_c   = DIV_W'(bytes) + DIV_W'(dv_c) - DIV_W'(1);
		rem_c   = rem_q;
		numsh_c = num_q;
		trial_c = '0;
		for (int k = 0; k < 2; k++) begin
			trial_c = {rem_c, numsh_c[DIV_W-1]};
			if (trial_c >= {1'b0, dv_q}) begin
				rem_c   = SIZE_W'(trial_c - {1'b0, dv_q});
				numsh_c = {numsh_c[DIV_W-2:0], 1'b1};
			end else begin
				rem_c   = trial_c[SIZE_W-1:0];
				numsh_c = {numsh_c[DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dv_q  <= dv_c;
			rem_q <= '0;
			num_q <= num_c;
		end else if (busy_q) begin
			rem_q <= rem_c;
			num_q <= numsh_c;
		end
	end

	// quotient has shifted fully into num_q when done rises
	assign res.done = done_q;
	assign res.quot = num_q;

endmodule

// ===== design/bffra_map_mem.sv =====
module bffra_map_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [bffra_pkg::WORD_W-1:0]   wdata,
	input  logic [AW-1:0]                  raddr,
	output logic [bffra_pkg::WORD_W-1:0]   rdata
);
	import bffra_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bitmap_first_fit_run_allocator.sv =====
// channel  direction  handshake              payload
// cfg      in         cfg_we                 cfg_index, cfg_data
// in       in         in_valid / in_ready    req_type, value_bytes, start_index
// out      out        out_valid / out_ready  status, granted_start, slots_used
//
// One transaction at a time. Slot count division: two quotient bits per cycle.
// Allocate scan: one map word (8 slots) per cycle, after a read state (S_SCAN_RD).
// Marking or clearing a run: each map word touched is read, then written back.
// After reset the map is swept to zero with in_ready low.
// A waiting result stalls only the next transaction's final step.
module bitmap_first_fit_run_allocator #(
	parameter int MAX_ENTRIES = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bffra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bffra_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [bffra_pkg::BYTES_W-1:0]     value_bytes,
	input  logic [bffra_pkg::START_W-1:0]     start_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bffra_pkg::STAT_W-1:0]      status,
	output logic [bffra_pkg::START_W-1:0]     granted_start,
	output logic [bffra_pkg::USED_W-1:0]      slots_used
);
	import bffra_pkg::*;

	localparam int WORDS = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int SW    = (WA_W + WORD_SH + 1 > CNT_W + 1) ? WA_W + WORD_SH + 1 : CNT_W + 1;
	localparam int EW    = DIV_W + 1;
	localparam int LW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	typedef enum logic [8:0] {
		S_CLEAR   = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_DIV     = 9'b000000100,
		S_EVAL    = 9'b000001000,
		S_SCAN_RD = 9'b000010000,
		S_SCAN    = 9'b000100000,
		S_MARK_RD = 9'b001000000,
		S_MARK_WR = 9'b010000000,
		S_RESP    = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [SIZE_W-1:0]  entry_size_q;
	req_t               req_q;
	logic [START_W-1:0] start_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   need_q;
	logic [IDX_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic               set_q;
	logic [WA_W-1:0]    w_q;
	logic [CNT_W-1:0]   run_q;
	logic [IDX_W-1:0]   rs_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [START_W-1:0] res_start_q;
	logic [USED_W-1:0]  res_used_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [START_W-1:0] out_start_q;
	logic [USED_W-1:0]  out_used_q;

	div_res_t           div_res;
	logic               div_go;

	logic               mem_we;
	logic [WA_W-1:0]    mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;
	logic [WA_W-1:0]    mem_raddr;
	logic [WORD_W-1:0]  mem_rdata;

	logic [LW-1:0]      ec_w;
	logic [LW-1:0]      mx_w;
	logic [CNT_W-1:0]   live_c;

	logic               need_zero_c;
	logic               need_fits_c;
	logic [EW-1:0]      end_c;
	logic               oor_c;
	logic               start_in_c;
	logic [USED_W-1:0]  used_c;

	logic [SW-1:0]      sslot_c;
	logic [CNT_W-1:0]   run_c;
	logic [IDX_W-1:0]   rs_c;
	logic               fnd_c;
	logic [SW-1:0]      next_base_c;
	logic               scan_end_c;
	logic               mark_end_c;
	logic [SW-1:0]      mslot_c;
	logic [WORD_W-1:0]  mark_c;

	assign in_ready = (state_q == S_IDLE);
	assign div_go   = in_valid && (state_q == S_IDLE);

	bffra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.bytes  (value_bytes),
		.size   (entry_size_q),
		.res    (div_res)
	);

	bffra_map_mem #(
		.DEPTH (WORDS),
		.AW    (WA_W)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		ec_w   = LW'(entry_count_q);
		mx_w   = LW'(MAX_ENTRIES);
		live_c = (ec_w > mx_w) ? mx_w[CNT_W-1:0] : ec_w[CNT_W-1:0];
	end

	always_comb begin
		need_zero_c = (div_res.quot == '0);
		need_fits_c = EW'(div_res.quot) <= EW'(cnt_q);
		end_c       = EW'(start_q) + EW'(div_res.quot);
		oor_c       = end_c > EW'(cnt_q);
		start_in_c  = EW'(start_q) < EW'(cnt_q);
		used_c      = (div_res.quot > DIV_W'(USED_MAX)) ? USED_MAX :
		              div_res.quot[USED_W-1:0];
	end

	// first-fit run tracking across the 8 slots of the current word
	always_comb begin
		run_c   = run_q;
		rs_c    = rs_q;
		fnd_c   = 1'b0;
		sslot_c = '0;
		for (int b = 0; b < WORD_W; b++) begin
			sslot_c = SW'({w_q, WORD_SH'(b)});
			if (!fnd_c && (sslot_c < SW'(cnt_q))) begin
				if (mem_rdata[b]) begin
					run_c = '0;
				end else begin
					if (run_c == '0) begin
						rs_c = IDX_W'(sslot_c);
					end
					run_c = run_c + 1'b1;
					if (run_c == need_q) begin
						fnd_c = 1'b1;
					end
				end
			end
		end
		next_base_c = SW'({w_q, WORD_SH'(0)}) + SW'(WORD_W);
		scan_end_c  = next_base_c >= SW'(cnt_q);
		mark_end_c  = next_base_c >= SW'(hi_q);
	end

	always_comb begin
		mslot_c = '0;
		mark_c  = mem_rdata;
		for (int b = 0; b < WORD_W; b++) begin
			mslot_c = SW'({w_q, WORD_SH'(b)});
			if ((mslot_c >= SW'(lo_q)) && (mslot_c < SW'(hi_q))) begin
				mark_c[b] = set_q;
			end
		end
	end

	// read-modify-write touches word w then w+1: no same-word overlap to forward
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = w_q;
		mem_wdata = '0;
		mem_raddr = w_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_SCAN: begin
				mem_raddr = scan_end_c ? '0 : w_q + 1'b1;
			end
			S_MARK_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mark_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			entry_count_q <= RST_ENTRY_COUNT;
			entry_size_q  <= RST_ENTRY_SIZE;
			req_q         <= REQ_ALLOC;
			start_q       <= '0;
			cnt_q         <= '0;
			need_q        <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			set_q         <= 1'b0;
			w_q           <= '0;
			run_q         <= '0;
			rs_q          <= '0;
			res_status_q  <= ST_OK;
			res_start_q   <= '0;
			res_used_q    <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_OK;
			out_start_q   <= '0;
			out_used_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENTRY_COUNT: entry_count_q <= cfg_data[COUNT_W-1:0];
					REG_ENTRY_SIZE:  entry_size_q  <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					if (w_q == WA_W'(WORDS - 1)) begin
						w_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_t'(req_type);
						start_q <= start_index;
						cnt_q   <= live_c;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_used_q  <= used_c;
					res_start_q <= '0;
					if (req_q == REQ_ALLOC) begin
						if (need_zero_c || !need_fits_c) begin
							res_status_q <= ST_NO_SPACE;
							state_q      <= S_RESP;
						end else begin
							res_status_q <= ST_OK;
							need_q       <= div_res.quot[CNT_W-1:0];
							run_q        <= '0;
							rs_q         <= '0;
							w_q          <= '0;
							state_q      <= S_SCAN_RD;
						end
					end else begin
						res_status_q <= (!need_zero_c && oor_c) ? ST_OUT_OF_RANGE : ST_OK;
						if (need_zero_c || !start_in_c) begin
							state_q <= S_RESP;
						end else begin
							lo_q    <= IDX_W'(start_q);
							hi_q    <= oor_c ? cnt_q : end_c[CNT_W-1:0];
							set_q   <= 1'b0;
							w_q     <= WA_W'(start_q >> WORD_SH);
							state_q <= S_MARK_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					run_q <= run_c;
					rs_q  <= rs_c;
					if (fnd_c) begin
						lo_q        <= rs_c;
						hi_q        <= CNT_W'(rs_c) + need_q;
						set_q       <= 1'b1;
						res_start_q <= START_W'(rs_c);
						w_q         <= WA_W'(rs_c >> WORD_SH);
						state_q     <= S_MARK_RD;
					end else if (scan_end_c) begin
						res_status_q <= ST_NO_SPACE;
						state_q      <= S_RESP;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (mark_end_c) begin
						state_q <= S_RESP;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_MARK_RD;
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_start_q  <= res_start_q;
						out_used_q   <= res_used_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_start = out_start_q;
	assign slots_used    = out_used_q;

endmodule

// ===== design/bffra_chk.sv =====
module bffra_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [bffra_pkg::STAT_W-1:0]   status,
	input  logic [bffra_pkg::START_W-1:0]  granted_start,
	input  logic [bffra_pkg::USED_W-1:0]   slots_used
);
	import bffra_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_start) && $stable(slots_used))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_NO_SPACE ||
		status == ST_OUT_OF_RANGE)
		else $error("bad status code");

	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_start == '0)
		else $error("failed transaction carries a start slot");

	a_used_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> slots_used <= USED_MAX)
		else $error("slots_used not saturated");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

endmodule

bind bitmap_first_fit_run_allocator bffra_chk u_bffra_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.granted_start (granted_start),
	.slots_used    (slots_used)
);
